@@ hw/rtl/shfc_pkg.sv @@
package shfc_pkg;

	localparam int unsigned OperandWidth = 32;

	localparam logic [30:0] F32Inf    = 31'h7F80_0000;
	localparam logic [30:0] F32MaxH   = 31'h477F_E000;
	localparam logic [30:0] F32MinH   = 31'h3880_0000;
	localparam logic [30:0] F32NanMin = 31'h7F80_2000;
	localparam logic [17:0] BiasDiff  = 18'h1_C000;

	typedef enum logic {
		REQ_S2H = 1'b0,
		REQ_H2S = 1'b1
	} req_type_t;

	// Class of the operand, decided in the first stage.
	typedef enum logic [2:0] {
		CLS_TINY   = 3'd0,
		CLS_NORMAL = 3'd1,
		CLS_INF    = 3'd2,
		CLS_NANLO  = 3'd3,
		CLS_NANHI  = 3'd4,
		CLS_HSPEC  = 3'd5,
		CLS_HNORM  = 3'd6,
		CLS_HSUB   = 3'd7
	} cls_t;

	typedef struct packed {
		logic        sign;
		cls_t        cls;
		logic [30:0] mag;
		logic [4:0]  shamt;
	} decode_t;

endpackage

@@ hw/rtl/shfc_if.sv @@
interface shfc_if #(
	parameter int unsigned Width = 32
);
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [Width-1:0] operand;
	logic [Width-1:0] converted;

	modport source (output valid, req_type, operand, converted, input ready);
	modport sink (input valid, req_type, operand, converted, output ready);
endinterface

@@ hw/rtl/single_half_float_converter.sv @@
// Each accepted input beat passes through stage registers s1, s2 and s3 before its result reaches the output.
// Throughput: one beat per cycle while the output is not stalled; the three stage registers advance together.
// A stall on the output holds every stage in place, so nothing is lost or repeated.
// Reset (arst_n low) clears all stage valid bits at once; payload is not reset.
module single_half_float_converter (
	input  logic      clk,
	input  logic      arst_n,
	shfc_if.sink      in_ch,
	shfc_if.source    out_ch
);
	import shfc_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        req_s1;
	logic [31:0] op_s1;
	decode_t     dec_w, dec_s2;
	logic [31:0] res_w, res_s3;
	logic        adv;

	assign adv = out_ch.ready || !v_s3;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s3;
	assign out_ch.converted = res_s3;
	assign out_ch.req_type = 1'b0;
	assign out_ch.operand = '0;

	shfc_decode u_dec (.req_type(req_s1), .operand(op_s1), .dec(dec_w));
	shfc_compose u_cmp (.dec(dec_s2), .result(res_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= in_ch.req_type;
			op_s1 <= in_ch.operand;
			dec_s2 <= dec_w;
			res_s3 <= res_w;
		end
	end
endmodule

@@ hw/rtl/shfc_decode.sv @@
module shfc_decode (
	input  logic                req_type,
	input  logic [31:0]         operand,
	output shfc_pkg::decode_t   dec
);
	import shfc_pkg::*;

	logic [30:0] mag;
	logic [7:0]  e;
	logic [8:0]  sh;
	logic [14:0] hv;
	logic [3:0]  lz;

	always_comb begin
		dec = '0;
		lz = 4'd0;
		sh = 9'd0;
		mag = operand[30:0];
		e = mag[30:23];
		hv = operand[14:0];
		if (req_type == REQ_S2H) begin
			dec.sign = operand[31];
			dec.mag = mag;
			if (mag < F32MinH) begin
				dec.cls = CLS_TINY;
				sh = (e == 8'd0) ? 9'd125 : (9'd126 - {1'b0, e});
				dec.shamt = (sh >= 9'd32) ? 5'd31 : sh[4:0];
				if (sh >= 9'd32) dec.mag = '0;
			end else if (mag <= F32MaxH) begin
				dec.cls = CLS_NORMAL;
			end else if (mag <= F32Inf) begin
				dec.cls = CLS_INF;
			end else if (mag < F32NanMin) begin
				dec.cls = CLS_NANLO;
			end else begin
				dec.cls = CLS_NANHI;
			end
		end else begin
			dec.sign = operand[15];
			dec.mag = {16'd0, hv};
			for (int i = 0; i < 10; i++) begin
				if (hv[i]) lz = 4'(9 - i);
			end
			dec.shamt = {1'b0, lz};
			if (hv[14:10] == 5'h1F) dec.cls = CLS_HSPEC;
			else if (hv[14:10] != 5'd0) dec.cls = CLS_HNORM;
			else dec.cls = CLS_HSUB;
		end
	end
endmodule

@@ hw/rtl/shfc_compose.sv @@
module shfc_compose (
	input  shfc_pkg::decode_t dec,
	output logic [31:0]       result
);
	import shfc_pkg::*;

	logic [23:0] sig;
	logic [15:0] h;
	logic [9:0]  m;
	logic [9:0]  msh;

	always_comb begin
		sig = {(dec.mag[30:23] != 8'd0), dec.mag[22:0]};
		m = dec.mag[9:0];
		msh = m << (dec.shamt[3:0] + 4'd1);
		h = '0;
		result = '0;
		unique case (dec.cls)
			CLS_TINY:   h = 16'(sig >> dec.shamt);
			CLS_NORMAL: h = 16'(18'(dec.mag[30:13]) - BiasDiff);
			CLS_INF:    h = 16'h7C00;
			CLS_NANLO:  h = 16'h7C01;
			CLS_NANHI:  h = 16'(18'(dec.mag[30:13]) - {BiasDiff[16:0], 1'b0});
			CLS_HSPEC:  result = {dec.sign, 8'hFF, m, 13'd0};
			CLS_HNORM:  result = {dec.sign, 31'({dec.mag[14:0] + 18'(BiasDiff), 13'd0})};
			CLS_HSUB:   result = (m == 10'd0) ? {dec.sign, 31'd0} :
				{dec.sign, 8'(8'd112 - {4'd0, dec.shamt[3:0]} + 8'd1) - 8'd1, msh, 13'd0};
			default:    h = '0;
		endcase
		if (dec.cls == CLS_TINY || dec.cls == CLS_NORMAL || dec.cls == CLS_INF
				|| dec.cls == CLS_NANLO || dec.cls == CLS_NANHI) begin
			result = {16'd0, h | {dec.sign, 15'd0}};
		end
	end
endmodule

@@ tb/tb_single_half_float_converter.sv @@
`timescale 1ns / 1ps

module tb_single_half_float_converter;
	import shfc_pkg::*;

	typedef struct {
		req_type_t   dir;
		logic [31:0] operand;
		logic        known;
		logic [31:0] converted;
	} vector_t;

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	logic [31:0] pending_q[$];
	logic stim_done;

	shfc_if #(.Width(32)) in_ch ();
	shfc_if #(.Width(32)) out_ch ();

	single_half_float_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] to_half(logic [31:0] x);
		logic [15:0] sign;
		logic [31:0] mag;
		logic [31:0] h;
		logic [31:0] sig;
		logic [31:0] sh;
		sign = x[31] ? 16'h8000 : 16'h0000;
		mag = {1'b0, x[30:0]};
		if (mag < 32'h3880_0000) begin
			sig = {9'd0, mag[22:0]};
			if (mag[30:23] == 8'd0) begin
				sh = 32'd125;
			end else begin
				sig[23] = 1'b1;
				sh = 32'd126 - mag[30:23];
			end
			h = (sh >= 32) ? 32'd0 : (sig >> sh);
		end else if (mag <= 32'h477F_E000) begin
			h = (mag >> 13) - 32'h1_C000;
		end else if (mag <= 32'h7F80_0000) begin
			h = 32'h7C00;
		end else if (mag < 32'h7F80_2000) begin
			h = 32'h7C01;
		end else begin
			h = (mag >> 13) - 32'h3_8000;
		end
		return {16'd0, h[15:0] | sign};
	endfunction

	function automatic logic [31:0] to_single(logic [31:0] x);
		logic [4:0] e;
		logic [9:0] m;
		logic [31:0] r;
		int p;
		e = x[14:10];
		m = x[9:0];
		if (e == 5'd31) begin
			r = 32'h7F80_0000 | ({22'd0, m} << 13);
		end else if (e != 5'd0) begin
			r = ({17'd0, x[14:0]} + 32'h1_C000) << 13;
		end else if (m == 10'd0) begin
			r = 32'd0;
		end else begin
			p = 9;
			while (!m[p])
				p--;
			r = (32'(p + 103) << 23) | ((32'(m) << (23 - p)) & 32'h7F_FFFF);
		end
		return r | {x[15], 31'd0};
	endfunction

	function automatic logic [31:0] convert(req_type_t dir, logic [31:0] x);
		return (dir == REQ_H2S) ? to_single(x) : to_half(x);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %08h expected %08h", what, got, want);
		mismatches++;
	endtask

	vector_t directed[] = '{
		'{REQ_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{REQ_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
		'{REQ_S2H, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
		'{REQ_S2H, 32'h477F_E000, 1'b1, 32'h0000_7BFF},
		'{REQ_S2H, 32'h477F_E001, 1'b1, 32'h0000_7C00},
		'{REQ_S2H, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
		'{REQ_S2H, 32'h7F80_0001, 1'b1, 32'h0000_7C01},
		'{REQ_S2H, 32'hFF80_1FFF, 1'b1, 32'h0000_FC01},
		'{REQ_S2H, 32'h7FFF_FFFF, 1'b1, 32'h0000_7FFF},
		'{REQ_S2H, 32'h7FC0_2000, 1'b0, 32'h0},
		'{REQ_S2H, 32'h3880_0000, 1'b1, 32'h0000_0400},
		'{REQ_S2H, 32'h387F_FFFF, 1'b0, 32'h0},
		'{REQ_S2H, 32'h3380_0000, 1'b1, 32'h0000_0001},
		'{REQ_S2H, 32'hB37F_FFFF, 1'b1, 32'h0000_8000},
		'{REQ_S2H, 32'h0000_0001, 1'b1, 32'h0000_0000},
		'{REQ_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{REQ_H2S, 32'hFFFF_8000, 1'b1, 32'h8000_0000},
		'{REQ_H2S, 32'h0000_0001, 1'b1, 32'h3380_0000},
		'{REQ_H2S, 32'h0000_03FF, 1'b0, 32'h0},
		'{REQ_H2S, 32'h0000_0400, 1'b1, 32'h3880_0000},
		'{REQ_H2S, 32'h0000_7BFF, 1'b1, 32'h477F_E000},
		'{REQ_H2S, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
		'{REQ_H2S, 32'hABCD_FC00, 1'b1, 32'hFF80_0000},
		'{REQ_H2S, 32'h0000_7FFF, 1'b1, 32'h7FFF_E000},
		'{REQ_H2S, 32'h0000_3C00, 1'b1, 32'h3F80_0000}
	};

	task automatic send_beat(req_type_t dir, logic [31:0] x);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= dir;
		in_ch.operand <= x;
		pending_q.push_back(convert(dir, x));
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 5))
			0: x[30:23] = 8'hFF;
			1: x[30:23] = 8'($urandom_range(8'h66, 8'h71));
			2: x[30:23] = 8'($urandom_range(8'h70, 8'h8F));
			3: x[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
			default: ;
		endcase
		return x;
	endfunction

	initial begin
		int burst;
		int n;
		arst_n = 1'b0;
		stim_done = 1'b0;
		mismatches = 0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_S2H;
		in_ch.operand = '0;
		in_ch.converted = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows with a known answer are checked against the table as well.
		foreach (directed[i]) begin
			if (directed[i].known && convert(directed[i].dir, directed[i].operand)
					!== directed[i].converted)
				report_mismatch("table row", convert(directed[i].dir, directed[i].operand),
						directed[i].converted);
			send_beat(directed[i].dir, directed[i].operand);
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);

		n = 0;
		while (n < 600) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < 600; b++) begin
				send_beat(req_type_t'($urandom_range(0, 1)), random_operand());
				n++;
			end
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;
		stim_done <= 1'b1;
	end

	// The receiver alternates between long open windows and choppy stalls.
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			mode = $urandom_range(0, 99);
			if (mode < 10)
				out_ch.ready <= ~out_ch.ready;
			else if (mode < 70)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected beat", out_ch.converted, 32'h0);
			end else begin
				logic [31:0] want;
				want = pending_q.pop_front();
				if (out_ch.converted !== want)
					report_mismatch("converted", out_ch.converted, want);
			end
		end
	end

	initial begin
		@(posedge stim_done);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("single_half_float_converter test passed");
		else
			$display("single_half_float_converter test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("single_half_float_converter test failed");
		$finish;
	end

endmodule
